/* hw/rtl/floor_call_latch_round_robin_defines.svh */
// Assertion macros for the floor call latch RTL.
// Used by floor_call_latch_round_robin.sv; no other dependencies.
`ifndef FLOOR_CALL_LATCH_ROUND_ROBIN_DEFINES_SVH
`define FLOOR_CALL_LATCH_ROUND_ROBIN_DEFINES_SVH

`ifndef SYNTH
// Plain property sampled on i_clk, off during reset.
`define FCL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define FCL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define FCL_ASSERT(label, prop, msg)
`define FCL_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

/* hw/rtl/fcl_pkg.sv */
// Shared types, constants and helpers of the floor call latch.
// No dependencies.
package fcl_pkg;

    localparam int FLOORS_DEF = 4;
    localparam int CFG_FLOORS = 4;   // floors that have configured buttons
    localparam int LEVEL_W    = 10;
    localparam int KEY_W      = 8;
    localparam int FLOOR_W    = 3;
    localparam int FLAG_W     = 3;
    localparam int NEXT_W     = 2;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int LADDER_TOL = 5;
    localparam int CMP_W      = LEVEL_W + 2;

    localparam logic [FLAG_W-1:0] FLAG_UP    = 3'b001;
    localparam logic [FLAG_W-1:0] FLAG_DOWN  = 3'b010;
    localparam logic [FLAG_W-1:0] FLAG_PANEL = 3'b100;

    localparam logic [CFG_IDX_W-1:0] CFG_UP_LEVELS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_LEVELS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_PRESENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_PRESENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_KEYS   = 3'd4;

    localparam logic ACT_SAMPLE  = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    // level - tol < smp < level + tol, done in unsigned arithmetic
    function automatic logic level_match(input logic [LEVEL_W-1:0] lvl,
                                         input logic [LEVEL_W-1:0] smp);
        logic [CMP_W-1:0] l;
        logic [CMP_W-1:0] s;
        l = CMP_W'(lvl);
        s = CMP_W'(smp);
        return ((s + CMP_W'(LADDER_TOL)) > l) && (s < (l + CMP_W'(LADDER_TOL)));
    endfunction

endpackage

/* hw/rtl/floor_call_latch_round_robin.sv */
// Floor call latch with round-robin next-floor arbiter, top level.
// Depends on fcl_pkg and floor_call_latch_round_robin_defines.svh.
//
// Each item is accepted in S_IDLE, then walks the call flag memory in S_RUN
// (one read per floor, write-back in the cycle after the read), and is loaded
// into the output register in S_FIN once that register is free or being taken.
// The flag memory has a single read and a single write port, which sets the
// length of the walk. A new item is taken while the previous result still
// waits in the output register. Config writes are accepted every cycle.
`include "floor_call_latch_round_robin_defines.svh"

module floor_call_latch_round_robin #(
    parameter int FLOORS = fcl_pkg::FLOORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [fcl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fcl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // ladder_sample[9:0], key_code[17:10],
                                          // from_floor[20:18], zero[23:21]
    input  logic        i_s_axis_tuser,   // action[0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // found[0], next_floor[2:1],
                                          // pending_mask[6:3], zero[7]
);

    localparam int AW = (FLOORS > 1) ? $clog2(FLOORS) : 1;
    localparam int CW = $clog2(FLOORS + 1);
    localparam int LW = fcl_pkg::LEVEL_W;
    localparam int KW = fcl_pkg::KEY_W;
    localparam int FW = fcl_pkg::FLOOR_W;
    localparam int GW = fcl_pkg::FLAG_W;
    localparam int MW = fcl_pkg::MASK_W;
    localparam int XW = fcl_pkg::NEXT_W;
    localparam int CIW = $clog2(fcl_pkg::CFG_FLOORS);

    // configuration registers
    logic [4*LW-1:0] r_up_levels;
    logic [4*LW-1:0] r_down_levels;
    logic [MW-1:0]   r_up_present;
    logic [MW-1:0]   r_down_present;
    logic [4*KW-1:0] r_panel_keys;

    // sequencer state
    fcl_pkg::t_state r_state, n_state;
    logic            r_act;
    logic [LW-1:0]   r_sample;
    logic [KW-1:0]   r_key;
    logic [AW-1:0]   r_start;
    logic            r_clr;
    logic [AW-1:0]   r_addr, n_addr;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_pv;
    logic [AW-1:0]   r_pf;
    logic            r_found, n_found;
    logic [XW-1:0]   r_next, n_next;
    logic [MW-1:0]   r_mask, n_mask;

    // flag memory and its valid bits
    logic [GW-1:0]     mem [FLOORS];
    logic [FLOORS-1:0] r_vld;
    logic [GW-1:0]     r_rd_data;
    logic              r_rd_vld;

    // output register
    logic          r_o_valid;
    logic          r_o_found;
    logic [XW-1:0] r_o_next;
    logic [MW-1:0] r_o_mask;

    // control
    logic s_acc, rd_en, wr_en, o_load, last_rd;
    logic [GW-1:0] wr_data, cur, upd;
    logic [FW-1:0] pf3, in_from;
    logic          p_cfg, in_range;
    logic [CIW-1:0] pi;

    assign o_cfg_ready = 1'b1;
    assign s_acc   = i_s_axis_tvalid & o_s_axis_tready;
    assign last_rd = (r_cnt == CW'(FLOORS));

    assign in_from  = i_s_axis_tdata[20:18];
    assign in_range = in_from < FW'(FLOORS);

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            fcl_pkg::S_IDLE: if (s_acc) n_state = fcl_pkg::S_RUN;
            fcl_pkg::S_RUN:  if (last_rd && r_pv) n_state = fcl_pkg::S_FIN;
            fcl_pkg::S_FIN:  if (o_load) n_state = fcl_pkg::S_IDLE;
            default:         n_state = fcl_pkg::S_IDLE;
        endcase
    end

    // ---- state outputs ----
    always_comb begin
        o_s_axis_tready = 1'b0;
        rd_en           = 1'b0;
        o_load          = 1'b0;
        case (r_state)
            fcl_pkg::S_IDLE: o_s_axis_tready = 1'b1;
            fcl_pkg::S_RUN:  rd_en = !last_rd;
            fcl_pkg::S_FIN:  o_load = !r_o_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    // ---- per-floor modify ----
    always_comb begin
        pf3   = FW'(r_pf);
        p_cfg = pf3 < FW'(fcl_pkg::CFG_FLOORS);
        pi    = pf3[CIW-1:0];
        cur   = r_rd_vld ? r_rd_data : '0;
        upd   = cur;
        if (r_act == fcl_pkg::ACT_SAMPLE) begin
            if (p_cfg) begin
                if (r_key != '0 && r_key == r_panel_keys[pi*KW +: KW])
                    upd = upd | fcl_pkg::FLAG_PANEL;
                if (r_down_present[pi] &&
                    fcl_pkg::level_match(r_down_levels[pi*LW +: LW], r_sample))
                    upd = upd | fcl_pkg::FLAG_DOWN;
                else if (r_up_present[pi] &&
                         fcl_pkg::level_match(r_up_levels[pi*LW +: LW], r_sample))
                    upd = upd | fcl_pkg::FLAG_UP;
            end
            wr_en = r_pv;
        end else begin
            if (r_clr && r_pf == r_start)
                upd = '0;
            wr_en = r_pv && r_clr && r_pf == r_start;
        end
        wr_data = upd;
    end

    // ---- walk datapath ----
    always_comb begin
        n_addr  = r_addr;
        n_cnt   = r_cnt;
        n_found = r_found;
        n_next  = r_next;
        n_mask  = r_mask;
        if (s_acc) begin
            n_addr  = (i_s_axis_tuser == fcl_pkg::ACT_REQUEST && in_range) ?
                      AW'(in_from) : '0;
            n_cnt   = '0;
            n_found = 1'b0;
            n_next  = '0;
            n_mask  = '0;
        end else begin
            if (rd_en) begin
                n_addr = (r_addr == AW'(FLOORS - 1)) ? '0 : r_addr + AW'(1);
                n_cnt  = r_cnt + CW'(1);
            end
            if (r_state == fcl_pkg::S_RUN && r_pv) begin
                if (p_cfg && upd != '0)
                    n_mask[pi] = 1'b1;
                // round-robin pick: first visited floor with a call
                if (r_act == fcl_pkg::ACT_REQUEST && r_clr && !r_found && upd != '0) begin
                    n_found = 1'b1;
                    n_next  = pf3[XW-1:0];
                end
            end
        end
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_levels    <= '0;
            r_down_levels  <= '0;
            r_up_present   <= '0;
            r_down_present <= '0;
            r_panel_keys   <= '0;
            r_state        <= fcl_pkg::S_IDLE;
            r_pv           <= 1'b0;
            r_vld          <= '0;
            r_o_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    fcl_pkg::CFG_UP_LEVELS:    r_up_levels    <= i_cfg_data;
                    fcl_pkg::CFG_DOWN_LEVELS:  r_down_levels  <= i_cfg_data;
                    fcl_pkg::CFG_UP_PRESENT:   r_up_present   <= i_cfg_data[MW-1:0];
                    fcl_pkg::CFG_DOWN_PRESENT: r_down_present <= i_cfg_data[MW-1:0];
                    fcl_pkg::CFG_PANEL_KEYS:   r_panel_keys   <= i_cfg_data[4*KW-1:0];
                    default: ;
                endcase
            end
            r_state <= n_state;
            r_pv    <= rd_en;
            if (wr_en)
                r_vld[r_pf] <= 1'b1;
            if (o_load)
                r_o_valid <= 1'b1;
            else if (i_m_axis_tready)
                r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_cnt   <= n_cnt;
        r_found <= n_found;
        r_next  <= n_next;
        r_mask  <= n_mask;
        r_pf    <= r_addr;
        if (s_acc) begin
            r_act    <= i_s_axis_tuser;
            r_sample <= i_s_axis_tdata[LW-1:0];
            r_key    <= i_s_axis_tdata[LW+KW-1:LW];
            r_start  <= in_range ? AW'(in_from) : '0;
            r_clr    <= (i_s_axis_tuser == fcl_pkg::ACT_REQUEST) && in_range;
        end
        if (o_load) begin
            r_o_found <= r_found;
            r_o_next  <= r_next;
            r_o_mask  <= r_mask;
        end
    end

    // flag memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en)
            mem[r_pf] <= wr_data;
        if (rd_en) begin
            r_rd_data <= mem[r_addr];
            r_rd_vld  <= r_vld[r_addr];
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {1'b0, r_o_mask, r_o_next, r_o_found};

    // ---- assertions ----
    `FCL_ASSERT_IMPL(a_no_rw_clash, rd_en && wr_en, r_addr != r_pf, "read and write hit same entry")
    `FCL_ASSERT_IMPL(a_fin_after_walk, r_state == fcl_pkg::S_FIN, r_cnt == CW'(FLOORS), "walk ended early")
    `FCL_ASSERT_IMPL(a_unconf_floor_clear, wr_en && !p_cfg, wr_data == '0, "flag set on unconfigured floor")
    `FCL_ASSERT_IMPL(a_found_pending, r_o_valid && r_o_found, r_o_mask[r_o_next], "found floor not pending")

endmodule

/* test/tb_top.sv */
// Self-checking bench for floor_call_latch_round_robin: directed and random button samples
// and floor requests, checked against an in-bench model of the call flags and the scan.
// Depends on fcl_pkg and the RTL of floor_call_latch_round_robin.
module tb_top;

    localparam int LEVEL_W    = fcl_pkg::LEVEL_W;
    localparam int KEY_W      = fcl_pkg::KEY_W;
    localparam int FLOOR_W    = fcl_pkg::FLOOR_W;
    localparam int FLAG_W     = fcl_pkg::FLAG_W;
    localparam int NEXT_W     = fcl_pkg::NEXT_W;
    localparam int MASK_W     = fcl_pkg::MASK_W;
    localparam int CFG_IDX_W  = fcl_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = fcl_pkg::CFG_DATA_W;
    localparam int CFG_FLOORS = fcl_pkg::CFG_FLOORS;
    localparam int LADDER_TOL = fcl_pkg::LADDER_TOL;

    localparam logic [FLAG_W-1:0] FLAG_UP    = fcl_pkg::FLAG_UP;
    localparam logic [FLAG_W-1:0] FLAG_DOWN  = fcl_pkg::FLAG_DOWN;
    localparam logic [FLAG_W-1:0] FLAG_PANEL = fcl_pkg::FLAG_PANEL;

    localparam logic [CFG_IDX_W-1:0] CFG_UP_LEVELS    = fcl_pkg::CFG_UP_LEVELS;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_LEVELS  = fcl_pkg::CFG_DOWN_LEVELS;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_PRESENT   = fcl_pkg::CFG_UP_PRESENT;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_PRESENT = fcl_pkg::CFG_DOWN_PRESENT;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_KEYS   = fcl_pkg::CFG_PANEL_KEYS;

    localparam logic ACT_SAMPLE  = fcl_pkg::ACT_SAMPLE;
    localparam logic ACT_REQUEST = fcl_pkg::ACT_REQUEST;

    localparam int NFLOORS        = fcl_pkg::FLOORS_DEF;
    localparam int DRAIN_CYCLES   = NFLOORS + 8;
    localparam int HOLD_CYCLES    = 60;
    localparam int TIMEOUT_CYCLES = 200000;

    typedef struct packed {
        logic                found;
        logic [NEXT_W-1:0]   next_floor;
        logic [MASK_W-1:0]   pending_mask;
    } t_call_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;

    // model copy of the registers and call flags
    logic [CFG_DATA_W-1:0]     cfg_up_levels;
    logic [CFG_DATA_W-1:0]     cfg_down_levels;
    logic [CFG_FLOORS-1:0]     cfg_up_present;
    logic [CFG_FLOORS-1:0]     cfg_down_present;
    logic [KEY_W*CFG_FLOORS-1:0] cfg_panel_keys;
    logic [FLAG_W-1:0]         call_flags [NFLOORS];

    t_call_result expected_calls[$];
    int err_count = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req   = 1'b0;

    floor_call_latch_round_robin #(.FLOORS(NFLOORS)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // strict window: L-5 < R < L+5
    function automatic bit ladder_hit(input logic [LEVEL_W-1:0] lvl,
                                      input logic [LEVEL_W-1:0] smp);
        int l;
        int r;
        l = int'(lvl);
        r = int'(smp);
        return (l - LADDER_TOL < r) && (r < l + LADDER_TOL);
    endfunction

    function automatic t_call_result latch_and_arbitrate(input logic act,
            input logic [LEVEL_W-1:0] smp, input logic [KEY_W-1:0] key,
            input logic [FLOOR_W-1:0] flr);
        t_call_result res;
        int idx;
        res = '0;
        if (act == ACT_SAMPLE) begin
            for (int f = 0; f < CFG_FLOORS && f < NFLOORS; f++) begin
                if (key != '0 && key == cfg_panel_keys[KEY_W*f +: KEY_W])
                    call_flags[f] |= FLAG_PANEL;
                // down wins over up on the same floor
                if (cfg_down_present[f] && ladder_hit(cfg_down_levels[LEVEL_W*f +: LEVEL_W], smp))
                    call_flags[f] |= FLAG_DOWN;
                else if (cfg_up_present[f] &&
                         ladder_hit(cfg_up_levels[LEVEL_W*f +: LEVEL_W], smp))
                    call_flags[f] |= FLAG_UP;
            end
        end else if (flr < NFLOORS) begin
            call_flags[flr] = '0;
            for (int k = 0; k < NFLOORS; k++) begin
                idx = (int'(flr) + k) % NFLOORS;
                if (!res.found && call_flags[idx] != '0) begin
                    res.found      = 1'b1;
                    res.next_floor = idx[NEXT_W-1:0];
                end
            end
        end
        for (int f = 0; f < CFG_FLOORS && f < NFLOORS; f++)
            res.pending_mask[f] = |call_flags[f];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_UP_LEVELS:    cfg_up_levels    = data;
            CFG_DOWN_LEVELS:  cfg_down_levels  = data;
            CFG_UP_PRESENT:   cfg_up_present   = data[CFG_FLOORS-1:0];
            CFG_DOWN_PRESENT: cfg_down_present = data[CFG_FLOORS-1:0];
            CFG_PANEL_KEYS:   cfg_panel_keys   = data[KEY_W*CFG_FLOORS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_item(input logic act, input logic [LEVEL_W-1:0] smp,
                             input logic [KEY_W-1:0] key, input logic [FLOOR_W-1:0] flr);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {3'b000, flr, key, smp};
        i_s_axis_tuser  = act;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_calls.push_back(latch_and_arbitrate(act, smp, key, flr));
    endtask

    // drop valid, let every expected result come back, then let the pipe settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (expected_calls.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_random_config();
        wait_idle();
        write_reg(CFG_UP_LEVELS, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(CFG_DOWN_LEVELS, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(CFG_UP_PRESENT, CFG_DATA_W'($urandom_range(0, 15)));
        write_reg(CFG_DOWN_PRESENT, CFG_DATA_W'($urandom_range(0, 15)));
        write_reg(CFG_PANEL_KEYS, CFG_DATA_W'($urandom));
    endtask

    // mostly samples near a configured level and requests on real floors, some noise
    task automatic run_random(input int n);
        int r;
        int f;
        int kf;
        int s;
        logic [KEY_W-1:0] key;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            f = $urandom_range(0, CFG_FLOORS - 1);
            s = $urandom_range(0, 1) ? int'(cfg_up_levels[LEVEL_W*f +: LEVEL_W])
                                     : int'(cfg_down_levels[LEVEL_W*f +: LEVEL_W]);
            s = s + int'($urandom_range(0, 12)) - 6;
            if (s < 0) s = 0;
            if (s > 1023) s = 1023;
            kf = $urandom_range(0, CFG_FLOORS - 1);
            case ($urandom_range(0, 3))
                0:       key = '0;
                1:       key = KEY_W'($urandom);
                default: key = cfg_panel_keys[KEY_W*kf +: KEY_W];
            endcase
            if (r < 5)
                send_item(ACT_SAMPLE, LEVEL_W'(s), key, FLOOR_W'($urandom));
            else if (r < 8)
                send_item(ACT_REQUEST, LEVEL_W'($urandom), KEY_W'($urandom),
                          FLOOR_W'($urandom_range(0, NFLOORS - 1)));
            else
                send_item(1'($urandom), LEVEL_W'($urandom), KEY_W'($urandom),
                          FLOOR_W'($urandom));
        end
    endtask

    // all registers still zero: no button present, key 0 against panel key 0
    task automatic test_reset_state();
        send_item(ACT_SAMPLE, 10'd0, 8'h00, 3'd0);
        send_item(ACT_SAMPLE, 10'd1023, 8'hFF, 3'd7);
        send_item(ACT_REQUEST, 10'd0, 8'h00, 3'd0);
    endtask

    task automatic test_ladder_edges();
        wait_idle();
        write_reg(CFG_UP_LEVELS, {10'd500, 10'd200, 10'd1023, 10'd0});
        write_reg(CFG_DOWN_LEVELS, {10'd40, 10'd203, 10'd900, 10'd700});
        write_reg(CFG_UP_PRESENT, CFG_DATA_W'(4'b1111));
        write_reg(CFG_DOWN_PRESENT, CFG_DATA_W'(4'b0111));
        write_reg(CFG_PANEL_KEYS, CFG_DATA_W'({8'h00, 8'h80, 8'hFF, 8'h01}));
        // just outside each window
        send_item(ACT_SAMPLE, 10'd5, 8'h00, 3'd0);
        send_item(ACT_SAMPLE, 10'd1018, 8'h00, 3'd0);
        send_item(ACT_SAMPLE, 10'd495, 8'h00, 3'd0);
        send_item(ACT_SAMPLE, 10'd505, 8'h00, 3'd0);
        // just inside
        send_item(ACT_SAMPLE, 10'd4, 8'h00, 3'd0);
        send_item(ACT_SAMPLE, 10'd1019, 8'h00, 3'd0);
        send_item(ACT_SAMPLE, 10'd504, 8'h00, 3'd0);
        // floor 3 has no down button
        send_item(ACT_SAMPLE, 10'd40, 8'h00, 3'd0);
        send_item(ACT_REQUEST, 10'd0, 8'h00, 3'd3);
        send_item(ACT_REQUEST, 10'd0, 8'h00, 3'd1);
        send_item(ACT_REQUEST, 10'd0, 8'h00, 3'd0);
    endtask

    task automatic test_down_before_up();
        send_item(ACT_SAMPLE, 10'd201, 8'h00, 3'd0);
        send_item(ACT_REQUEST, 10'd0, 8'h00, 3'd2);
        send_item(ACT_SAMPLE, 10'd196, 8'h00, 3'd0);
        send_item(ACT_REQUEST, 10'd0, 8'h00, 3'd3);
    endtask

    task automatic test_panel_keys();
        send_item(ACT_SAMPLE, 10'd600, 8'h00, 3'd0);
        send_item(ACT_SAMPLE, 10'd600, 8'hFF, 3'd0);
        send_item(ACT_SAMPLE, 10'd600, 8'h80, 3'd0);
        send_item(ACT_SAMPLE, 10'd600, 8'h01, 3'd0);
        send_item(ACT_REQUEST, 10'd0, 8'h00, 3'd2);
    endtask

    task automatic test_floor_out_of_range();
        for (int f = NFLOORS; f < 8; f++)
            send_item(ACT_REQUEST, 10'h3FF, 8'hFF, FLOOR_W'(f));
    endtask

    task automatic test_config_extremes();
        wait_idle();
        write_reg(CFG_UP_LEVELS, '1);
        write_reg(CFG_DOWN_LEVELS, '1);
        write_reg(CFG_UP_PRESENT, CFG_DATA_W'(4'hF));
        write_reg(CFG_DOWN_PRESENT, CFG_DATA_W'(4'hF));
        write_reg(CFG_PANEL_KEYS, CFG_DATA_W'(32'hFFFF_FFFF));
        run_random(40);
        wait_idle();
        write_reg(CFG_UP_LEVELS, '0);
        write_reg(CFG_DOWN_LEVELS, '0);
        write_reg(CFG_PANEL_KEYS, '0);
        run_random(40);
    endtask

    task automatic test_random_mix();
        for (int p = 0; p < 4; p++) begin
            write_random_config();
            run_random(130);
        end
    endtask

    // receiver holds off while items keep coming, so the input has to stall
    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_req   = 1'b1;
        run_random(30);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_no_gaps();
        write_random_config();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random(120);
    endtask

    // result side ready, with random stalls and an optional long hold-off
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_call_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_calls.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata=%h", o_m_axis_tdata));
            end else begin
                want = expected_calls.pop_front();
                if (o_m_axis_tdata[0] !== want.found)
                    report_mismatch($sformatf("found %b, want %b",
                                              o_m_axis_tdata[0], want.found));
                if (o_m_axis_tdata[2:1] !== want.next_floor)
                    report_mismatch($sformatf("next_floor %0d, want %0d",
                                              o_m_axis_tdata[2:1], want.next_floor));
                if (o_m_axis_tdata[6:3] !== want.pending_mask)
                    report_mismatch($sformatf("pending_mask %b, want %b",
                                              o_m_axis_tdata[6:3], want.pending_mask));
                if (o_m_axis_tdata[7] !== 1'b0)
                    report_mismatch("tdata pad bit not zero");
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        cfg_up_levels    = '0;
        cfg_down_levels  = '0;
        cfg_up_present   = '0;
        cfg_down_present = '0;
        cfg_panel_keys   = '0;
        for (int f = 0; f < NFLOORS; f++)
            call_flags[f] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_ladder_edges();
        test_down_before_up();
        test_panel_keys();
        test_floor_out_of_range();
        test_config_extremes();
        test_random_mix();
        test_output_backpressure();
        test_no_gaps();
        wait_idle();

        if (expected_calls.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_calls.size()));
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/fcl_pkg.sv
hw/rtl/floor_call_latch_round_robin.sv
test/tb_top.sv
